// File: rtl/fppc_pkg.sv
package fppc_pkg;

  // Table geometry
  localparam int ENTRIES = 1024;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths fixed by the interface
  localparam int PORT_W   = 16;
  localparam int ADDR_W   = 32;
  localparam int PKT_W    = 32;
  localparam int EIDX_W   = 10;
  localparam int CFG_IDX_W = 8;

  localparam logic [PORT_W-1:0] PORT_A_RESET = 16'd8080;
  localparam logic [PORT_W-1:0] PORT_B_RESET = 16'd50070;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PORT_A = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_B = 8'd1;

  typedef struct packed {
    logic [PORT_W-1:0] src_port;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
  } in_item_t;

  typedef struct packed {
    logic              matched;
    logic [EIDX_W-1:0] entry_index;
    logic [PKT_W-1:0]  packet_count;
    logic              new_flow;
    logic              table_full;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic fin_nomatch;
    logic fin_hit;
    logic fin_miss;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic port_hit;
    logic hit;
    logic last;
    logic out_free;
  } status_t;

endpackage

// File: rtl/fppc_ctrl.sv
module fppc_ctrl import fppc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.port_hit) begin
          state_nxt = ST_SCAN;
        end else if (status.out_free) begin
          cmd.fin_nomatch = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // A hit on the entry just read wins over running off the end.
        if (status.hit) begin
          if (status.out_free) begin
            cmd.fin_hit = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else if (status.last) begin
          if (status.out_free) begin
            cmd.fin_miss = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/fppc_dp.sv
module fppc_dp import fppc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PORT_W-1:0]    cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  cmd_t                 cmd,
  output status_t              status
);

  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [PKT_W-1:0]  count;
  } entry_t;

  entry_t mem [ENTRIES];

  logic [PORT_W-1:0] port_a_r;
  logic [PORT_W-1:0] port_b_r;
  in_item_t          item_r;
  logic [CNT_W-1:0]  used_r;
  logic [CNT_W-1:0]  rd_ptr_r;
  logic [IDX_W-1:0]  pend_idx_r;
  logic              pend_vld_r;
  entry_t            rd_data_r;
  logic              out_vld_r;
  out_item_t         out_r;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic [PKT_W-1:0]  inc_count;
  logic              room;

  assign status.port_hit = (item_r.src_port == port_a_r) || (item_r.src_port == port_b_r);
  assign status.hit      = pend_vld_r && (rd_data_r.src == item_r.src_addr)
                           && (rd_data_r.dst == item_r.dst_addr);
  assign status.last     = (rd_ptr_r >= used_r);
  assign status.out_free = !out_vld_r || out_ready;

  assign room      = (used_r < CNT_W'(ENTRIES));
  assign inc_count = (rd_data_r.count == '1) ? rd_data_r.count : rd_data_r.count + 1'b1;

  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = pend_idx_r;
    wr_data.src   = item_r.src_addr;
    wr_data.dst   = item_r.dst_addr;
    wr_data.count = inc_count;
    if (cmd.fin_hit) begin
      wr_en = 1'b1;
    end else if (cmd.fin_miss && room) begin
      wr_en         = 1'b1;
      wr_addr       = used_r[IDX_W-1:0];
      wr_data.count = PKT_W'(1);
    end
  end

  // Table storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data_r  <= mem[rd_ptr_r[IDX_W-1:0]];
      pend_idx_r <= rd_ptr_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_a_r   <= PORT_A_RESET;
      port_b_r   <= PORT_B_RESET;
      used_r     <= '0;
      rd_ptr_r   <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_PORT_A) begin
          port_a_r <= cfg_data;
        end else if (cfg_index == REG_PORT_B) begin
          port_b_r <= cfg_data;
        end
      end
      if (cmd.load) begin
        rd_ptr_r   <= '0;
        pend_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        rd_ptr_r   <= rd_ptr_r + 1'b1;
        pend_vld_r <= 1'b1;
      end
      if (cmd.fin_miss && room) begin
        used_r <= used_r + 1'b1;
      end
      if (cmd.fin_nomatch || cmd.fin_hit || cmd.fin_miss) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_nomatch) begin
      out_r <= '0;
    end else if (cmd.fin_hit) begin
      out_r.matched      <= 1'b1;
      out_r.entry_index  <= EIDX_W'(pend_idx_r);
      out_r.packet_count <= inc_count;
      out_r.new_flow     <= 1'b0;
      out_r.table_full   <= 1'b0;
    end else if (cmd.fin_miss) begin
      out_r.matched      <= 1'b1;
      out_r.entry_index  <= room ? EIDX_W'(used_r[IDX_W-1:0]) : '0;
      out_r.packet_count <= room ? PKT_W'(1) : '0;
      out_r.new_flow     <= room;
      out_r.table_full   <= !room;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(ENTRIES))
    else $error("fill count beyond table size");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan, cmd.fin_nomatch, cmd.fin_hit, cmd.fin_miss}))
    else $error("more than one datapath command at once");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin_nomatch || cmd.fin_hit || cmd.fin_miss) |-> (!out_vld_r || out_ready))
    else $error("result overwrites one not yet transferred");

  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_hit |-> (pend_vld_r && ({1'b0, pend_idx_r} < used_r)))
    else $error("hit on an entry that is not stored");

endmodule

// File: rtl/flow_pair_packet_counter.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_item_t  (src_port, src_addr, dst_addr)
// out_      output     out_valid / out_ready  out_item_t (matched .. table_full)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item whose port is not matched is answered without a table lookup. With the port
// matched, a linear scan reads one table entry a cycle over the stored pairs (up to
// 1024) and stops at a hit; a miss reads every stored pair, and adds the pair if there is room.
// Reset (synchronous, rst_n low) empties the table and restores the default ports.
// An item is taken while an earlier result still waits; the block stalls at the end of
// the new item until out_ready frees the output register. cfg_ready is always high.
module flow_pair_packet_counter import fppc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PORT_W-1:0]    cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  fppc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fppc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: test/flow_pair_packet_counter_tb.sv
module flow_pair_packet_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fppc_pkg::*;

  localparam int CYCLE_LIMIT = 6_000_000;
  // A matched packet that misses against a full table scans all ENTRIES entries.
  localparam int SETTLE_CYCLES = ENTRIES + 64;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_PACKETS = 100;
  localparam int FULL_TABLE_PACKETS = 48;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = REG_PORT_B + 1'b1;
  localparam out_item_t NOT_COUNTED = '0;

  typedef enum logic {ROW_PACKET, ROW_REG_WRITE} row_kind_e;
  typedef enum logic [1:0] {
    PACE_FULL, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH
  } pace_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [PORT_W-1:0]      reg_value;
    in_item_t               pkt;
    logic                   typed;
    out_item_t              want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PORT_W-1:0]    cfg_data = '0;

  // Sideband travelling with each packet: a hand-typed result for directed rows.
  logic      note_typed = 1'b0;
  out_item_t note_want = '0;

  always #5 clk = ~clk;

  flow_pair_packet_counter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Flow table mirror.
  logic [PORT_W-1:0] watch_port_a = PORT_A_RESET;
  logic [PORT_W-1:0] watch_port_b = PORT_B_RESET;
  int                pair_slot[logic [63:0]];
  logic [PKT_W-1:0]  pair_count[ENTRIES];
  int                pairs_used = 0;
  int                full_rejections = 0;

  out_item_t pending_tallies[$];
  out_item_t predicted;
  out_item_t oldest;
  logic [63:0] seen_pairs[$];

  int mismatches = 0;
  int results_checked = 0;
  int sent_packets = 0;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_len = 0;

  function automatic out_item_t count_packet(in_item_t pkt);
    out_item_t  res;
    logic [63:0] key;
    int         slot;
    res = '0;
    key = {pkt.src_addr, pkt.dst_addr};
    if (pkt.src_port != watch_port_a && pkt.src_port != watch_port_b) begin
      return res;
    end
    res.matched = 1'b1;
    if (pair_slot.exists(key)) begin
      slot = pair_slot[key];
      if (pair_count[slot] != '1) begin
        pair_count[slot] = pair_count[slot] + 1'b1;
      end
      res.entry_index  = slot[EIDX_W-1:0];
      res.packet_count = pair_count[slot];
    end else if (pairs_used < ENTRIES) begin
      pair_slot[key]         = pairs_used;
      pair_count[pairs_used] = 1;
      res.entry_index        = pairs_used[EIDX_W-1:0];
      res.packet_count       = 1;
      res.new_flow           = 1'b1;
      pairs_used++;
    end else begin
      res.table_full = 1'b1;
      full_rejections++;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
    end
  endtask

  function automatic stim_row_t packet_row(input logic [PORT_W-1:0] port,
                                           input logic [ADDR_W-1:0] sa,
                                           input logic [ADDR_W-1:0] da,
                                           input logic typed, input out_item_t want);
    stim_row_t row;
    row.kind      = ROW_PACKET;
    row.reg_index = '0;
    row.reg_value = '0;
    row.pkt       = '{src_port: port, src_addr: sa, dst_addr: da};
    row.typed     = typed;
    row.want      = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [PORT_W-1:0] val);
    stim_row_t row;
    row.kind      = ROW_REG_WRITE;
    row.reg_index = idx;
    row.reg_value = val;
    row.pkt       = '0;
    row.typed     = 1'b0;
    row.want      = '0;
    return row;
  endfunction

  // Scoreboard: results are checked before the same edge's input transfer is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_tallies.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(out_data), '0);
        end else begin
          oldest = pending_tallies.pop_front();
          results_checked++;
          if (out_data.matched != oldest.matched)
            report_mismatch("matched", 64'(out_data.matched), 64'(oldest.matched));
          if (out_data.entry_index != oldest.entry_index)
            report_mismatch("entry_index", 64'(out_data.entry_index),
                            64'(oldest.entry_index));
          if (out_data.packet_count != oldest.packet_count)
            report_mismatch("packet_count", 64'(out_data.packet_count),
                            64'(oldest.packet_count));
          if (out_data.new_flow != oldest.new_flow)
            report_mismatch("new_flow", 64'(out_data.new_flow), 64'(oldest.new_flow));
          if (out_data.table_full != oldest.table_full)
            report_mismatch("table_full", 64'(out_data.table_full),
                            64'(oldest.table_full));
        end
      end
      if (in_valid && in_ready) begin
        predicted = count_packet(in_data);
        pending_tallies.push_back(note_typed ? note_want : predicted);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PORT_A: watch_port_a = cfg_data;
          REG_PORT_B: watch_port_b = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_off_len != 0) begin
      out_ready    <= 1'b0;
      hold_off_len <= hold_off_len - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_tallies.size());
      $display("flow_pair_packet_counter_tb failed");
      $finish;
    end
  end

  task automatic set_pace(input pace_e pace);
    case (pace)
      PACE_FULL:            begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      PACE_SENDER_GAPS:     begin send_gap_pct = 51; recv_stall_pct = 0;  end
      PACE_RECEIVER_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 51; end
      default:              begin send_gap_pct = 6;  recv_stall_pct = 6;  end
    endcase
  endtask

  task automatic send_packet(input in_item_t pkt, input logic typed,
                             input out_item_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= pkt;
    note_typed <= typed;
    note_want  <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_packets++;
  endtask

  task automatic wait_for_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PORT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    stim_row_t   directed_rows[$];
    stim_row_t   row;
    in_item_t    pkt;
    logic [63:0] pair;
    logic [63:0] last_stored;
    int          r;
    int          need;

    // Fresh table, default ports, then both ports at their extremes and an
    // unmapped register write that must leave the ports alone, then both ports on one value.
    directed_rows.push_back(packet_row(16'd0, 32'h0, 32'h0, 1'b1, NOT_COUNTED));
    directed_rows.push_back(packet_row(16'hFFFF, '1, '1, 1'b1, NOT_COUNTED));
    directed_rows.push_back(packet_row(PORT_A_RESET, 32'h0, 32'h0, 1'b1,
                                       {1'b1, 10'd0, 32'd1, 1'b1, 1'b0}));
    directed_rows.push_back(packet_row(PORT_B_RESET, 32'h0, 32'h0, 1'b1,
                                       {1'b1, 10'd0, 32'd2, 1'b0, 1'b0}));
    directed_rows.push_back(packet_row(PORT_A_RESET, '1, '1, 1'b1,
                                       {1'b1, 10'd1, 32'd1, 1'b1, 1'b0}));
    directed_rows.push_back(packet_row(PORT_B_RESET, '1, 32'h0, 1'b1,
                                       {1'b1, 10'd2, 32'd1, 1'b1, 1'b0}));
    directed_rows.push_back(packet_row(PORT_A_RESET, 32'h0, '1, 1'b1,
                                       {1'b1, 10'd3, 32'd1, 1'b1, 1'b0}));
    directed_rows.push_back(packet_row(PORT_A_RESET - 1'b1, 32'h0, 32'h0, 1'b1,
                                       NOT_COUNTED));
    directed_rows.push_back(packet_row(PORT_B_RESET + 1'b1, 32'h0, 32'h0, 1'b1,
                                       NOT_COUNTED));
    directed_rows.push_back(packet_row(PORT_A_RESET, '1, '1, 1'b1,
                                       {1'b1, 10'd1, 32'd2, 1'b0, 1'b0}));
    directed_rows.push_back(reg_row(REG_PORT_A, 16'h0000));
    directed_rows.push_back(reg_row(REG_PORT_B, 16'hFFFF));
    directed_rows.push_back(packet_row(16'h0000, 32'h0, 32'h0, 1'b1,
                                       {1'b1, 10'd0, 32'd3, 1'b0, 1'b0}));
    directed_rows.push_back(packet_row(16'hFFFF, 32'h0, 32'h0, 1'b1,
                                       {1'b1, 10'd0, 32'd4, 1'b0, 1'b0}));
    directed_rows.push_back(packet_row(PORT_A_RESET, 32'h0, 32'h0, 1'b1, NOT_COUNTED));
    directed_rows.push_back(packet_row(PORT_B_RESET, 32'h0, 32'h0, 1'b1, NOT_COUNTED));
    directed_rows.push_back(reg_row(REG_UNMAPPED, PORT_A_RESET));
    directed_rows.push_back(packet_row(PORT_A_RESET, 32'h0, 32'h0, 1'b1, NOT_COUNTED));
    directed_rows.push_back(reg_row(REG_PORT_A, 16'h5A5A));
    directed_rows.push_back(reg_row(REG_PORT_B, 16'h5A5A));
    directed_rows.push_back(packet_row(16'h5A5A, 32'h12345678, 32'h9ABCDEF0, 1'b0, '0));
    directed_rows.push_back(packet_row(16'h5A5A, 32'h9ABCDEF0, 32'h12345678, 1'b0, '0));
    directed_rows.push_back(packet_row(16'h5A5A, 32'h12345678, 32'h9ABCDEF0, 1'b0, '0));
    directed_rows.push_back(packet_row(16'hA5A5, 32'h12345678, 32'h9ABCDEF0, 1'b0, '0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG_WRITE) begin
        wait_for_results();
        write_reg(row.reg_index, row.reg_value);
      end else begin
        seen_pairs.push_back({row.pkt.src_addr, row.pkt.dst_addr});
        send_packet(row.pkt, row.typed, row.want);
      end
    end

    // Random traffic: mostly repeat pairs so that counts climb, with some new
    // pairs, some half-familiar pairs and stray ports mixed in.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      case (phase)
        0: begin
          write_reg(REG_PORT_A, PORT_W'($urandom));
          write_reg(REG_PORT_B, PORT_W'($urandom));
        end
        1: begin
          write_reg(REG_PORT_A, 16'hFFFF);
          write_reg(REG_PORT_B, 16'h0000);
        end
        2: begin
          r = $urandom;
          write_reg(REG_PORT_A, r[PORT_W-1:0]);
          write_reg(REG_PORT_B, r[PORT_W-1:0]);
        end
        default: begin
          write_reg(REG_PORT_A, PORT_A_RESET);
          write_reg(REG_PORT_B, PORT_B_RESET);
        end
      endcase
      set_pace(pace_e'(phase));
      for (int i = 0; i < PHASE_PACKETS; i++) begin
        // Keep the output blocked for a long stretch while packets keep coming.
        if (phase == 2 && i == PHASE_PACKETS / 2) hold_off_len = 3000;
        r    = $urandom_range(99);
        pair = seen_pairs[$urandom_range(seen_pairs.size() - 1)];
        pkt.src_port = $urandom_range(1) ? watch_port_a : watch_port_b;
        if (r < 12) begin
          pkt.src_port = PORT_W'($urandom);
        end else if (r < 22) begin
          pair = {$urandom, $urandom};
          seen_pairs.push_back(pair);
        end else if (r < 32) begin
          pair[31:0] = $urandom;
        end
        pkt.src_addr = pair[63:32];
        pkt.dst_addr = pair[31:0];
        send_packet(pkt, 1'b0, '0);
      end
    end

    // Fill every remaining entry, then push on against the full table.
    wait_for_results();
    need = ENTRIES - pairs_used;
    for (int k = 0; k < need; k++) begin
      set_pace(pace_e'((k / 256) % 4));
      pair = {$urandom, $urandom};
      seen_pairs.push_back(pair);
      pkt = '{src_port: watch_port_a, src_addr: pair[63:32], dst_addr: pair[31:0]};
      send_packet(pkt, 1'b0, '0);
    end
    last_stored = seen_pairs[seen_pairs.size() - 1];

    set_pace(PACE_BOTH);
    for (int k = 0; k < FULL_TABLE_PACKETS; k++) begin
      pkt.src_port = watch_port_a;
      case (k % 4)
        0: pair = {$urandom, $urandom};
        1: begin
          pair = seen_pairs[$urandom_range(seen_pairs.size() - 1)];
          pkt.src_port = watch_port_b;
        end
        2: pair = last_stored;
        default: begin
          pair = seen_pairs[$urandom_range(seen_pairs.size() - 1)];
          pkt.src_port = PORT_W'($urandom);
        end
      endcase
      pkt.src_addr = pair[63:32];
      pkt.dst_addr = pair[31:0];
      send_packet(pkt, 1'b0, '0);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_tallies.size() != 0) begin
      report_mismatch("results never delivered", 64'(pending_tallies.size()), '0);
    end

    $display("Sent %0d packets over %0d cycles, %0d results checked, %0d mismatches.",
             sent_packets, cycle_count, results_checked, mismatches);
    $display("Flow table filled to %0d of %0d pairs; %0d new pairs turned away when full.",
             pairs_used, ENTRIES, full_rejections);
    if (mismatches == 0) begin
      $display("flow_pair_packet_counter_tb passed");
    end else begin
      $display("flow_pair_packet_counter_tb failed");
    end
    $finish;
  end

endmodule
